### sv/cls_pkg.sv
package cls_pkg;

  // Field widths fixed by the item format
  localparam int unsigned ValW       = 32;
  localparam int unsigned PosW       = 6;
  localparam int unsigned StatW      = 2;

  // Default list depth and cap on results of one dump
  localparam int unsigned DefDepth   = 32;
  localparam int unsigned MaxResults = 32;

  typedef enum logic [1:0] {
    OP_APPEND  = 2'd0,
    OP_REMOVE  = 2'd1,
    OP_DUMP    = 2'd2,
    OP_REPLACE = 2'd3
  } op_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_NOPOS = 2'd2,
    STAT_EMPTY = 2'd3
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic exec;        // carry out a single-result operation on the input item
    logic dump_start;  // clear the dump pointer
    logic dump_step;   // emit the entry at the dump pointer and advance
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic list_empty;
    logic dump_last;   // dump pointer is on the final entry to emit
  } dp_stat_t;

endpackage

### sv/compacting_list_store.sv
// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+-------------------------------------
// in       | input     | in_valid_i / in_ready_o  | operation_i, value_i, position_i
// out      | output    | out_valid_o / out_ready_i| value_out_o, index_out_o, status_o, last_o
//
// Append, remove, replace and a dump of an empty list each give one result;
// the entry cells shift down in parallel on a remove.
// A dump of N entries (N capped at 32) first clears the dump pointer, then gives
// one entry per cycle through the single cell read port while the output is free.
// Reset clears the entry count, the controller and the output valid flag.
// A stalled output holds its result; the next item or dump entry waits for it.
module compacting_list_store #(
  parameter int unsigned DEPTH = cls_pkg::DefDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      operation_i,
  input  logic signed [cls_pkg::ValW-1:0] value_i,
  input  logic [cls_pkg::PosW-1:0]        position_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [cls_pkg::ValW-1:0] value_out_o,
  output logic [cls_pkg::PosW-1:0]        index_out_o,
  output logic [cls_pkg::StatW-1:0]       status_o,
  output logic                            last_o
);

  cls_pkg::ctrl_cmd_t cmd;
  cls_pkg::dp_stat_t  stat;

  cls_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cls_datapath #(
    .Depth (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .operation_i (operation_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_out_o (value_out_o),
    .index_out_o (index_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule

### sv/cls_datapath.sv
module cls_datapath #(
  parameter int unsigned Depth = cls_pkg::DefDepth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cls_pkg::ctrl_cmd_t          cmd_i,
  output cls_pkg::dp_stat_t           stat_o,
  input  logic [1:0]                  operation_i,
  input  logic signed [cls_pkg::ValW-1:0] value_i,
  input  logic [cls_pkg::PosW-1:0]    position_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [cls_pkg::ValW-1:0] value_out_o,
  output logic [cls_pkg::PosW-1:0]    index_out_o,
  output logic [cls_pkg::StatW-1:0]   status_o,
  output logic                        last_o
);

  localparam int unsigned AW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW   = $clog2(Depth + 1);
  localparam int unsigned CmpW = (CW > cls_pkg::PosW) ? CW : cls_pkg::PosW;

  logic [cls_pkg::ValW-1:0] cells_q [Depth];
  logic [CW-1:0]            count_q, count_d;
  logic [AW-1:0]            ptr_q, ptr_d;

  logic                     out_valid_q, out_valid_d;
  logic [cls_pkg::ValW-1:0] out_value_q, res_value;
  logic [cls_pkg::PosW-1:0] out_index_q, res_index;
  cls_pkg::status_e         out_status_q, res_status;
  logic                     out_last_q, res_last;

  cls_pkg::op_e             op;
  logic [CmpW-1:0]          count_ext, pos_ext, dump_n;
  logic                     list_full, pos_zero, pos_past;
  logic [AW-1:0]            pos_idx, cnt_idx, rd_addr;
  logic [cls_pkg::ValW-1:0] rd_data;
  logic                     do_append, do_remove, do_replace;
  logic                     wr_append, wr_replace, wr_remove;
  logic                     dump_last, load;

  // Decode the item against the current count
  assign op         = cls_pkg::op_e'(operation_i);
  assign count_ext  = CmpW'(count_q);
  assign pos_ext    = CmpW'(position_i);
  assign list_full  = (count_q == CW'(Depth));
  assign pos_zero   = (position_i == '0);
  assign pos_past   = (pos_ext > count_ext);
  assign pos_idx    = AW'(position_i - cls_pkg::PosW'(1));
  assign cnt_idx    = count_q[AW-1:0];

  assign do_append  = (op == cls_pkg::OP_APPEND) ||
                      ((op == cls_pkg::OP_REPLACE) && !pos_zero && pos_past);
  assign do_remove  = (op == cls_pkg::OP_REMOVE) && !pos_zero && !pos_past;
  assign do_replace = (op == cls_pkg::OP_REPLACE) && !pos_zero && !pos_past;

  assign wr_append  = cmd_i.exec && do_append && !list_full;
  assign wr_replace = cmd_i.exec && do_replace;
  assign wr_remove  = cmd_i.exec && do_remove;

  // Single read port, shared by remove and dump
  assign rd_addr = cmd_i.dump_step ? ptr_q : pos_idx;
  assign rd_data = cells_q[rd_addr];

  // Dump length is capped at the result limit
  assign dump_n    = (count_ext > CmpW'(cls_pkg::MaxResults)) ?
                     CmpW'(cls_pkg::MaxResults) : count_ext;
  assign dump_last = ((CmpW'(ptr_q) + CmpW'(1)) == dump_n);

  // Entry cells: write at the end, overwrite in place, or shift down
  for (genvar k = 0; k < Depth; k++) begin : g_cell
    logic [cls_pkg::ValW-1:0] shift_in;
    logic [cls_pkg::ValW-1:0] cell_d;
    logic                     cell_we;

    if (k < Depth - 1) begin : g_shift
      assign shift_in = cells_q[k+1];
    end else begin : g_tail
      assign shift_in = cells_q[k];
    end

    always_comb begin
      cell_we = 1'b0;
      cell_d  = value_i;
      if (wr_append && (cnt_idx == AW'(k))) begin
        cell_we = 1'b1;
      end
      if (wr_replace && (pos_idx == AW'(k))) begin
        cell_we = 1'b1;
      end
      if (wr_remove && (AW'(k) >= pos_idx)) begin
        cell_we = 1'b1;
        cell_d  = shift_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (cell_we) begin
        cells_q[k] <= cell_d;
      end
    end
  end

  // Result of the current operation or dump step
  always_comb begin
    res_value  = value_i;
    res_index  = '0;
    res_status = cls_pkg::STAT_OK;
    res_last   = 1'b1;
    if (cmd_i.dump_step) begin
      res_value = rd_data;
      res_index = cls_pkg::PosW'(ptr_q) + cls_pkg::PosW'(1);
      res_last  = dump_last;
    end else begin
      case (op)
        cls_pkg::OP_REMOVE: begin
          res_index = position_i;
          if (do_remove) begin
            res_value = rd_data;
          end else begin
            res_value  = '0;
            res_status = cls_pkg::STAT_NOPOS;
          end
        end
        cls_pkg::OP_DUMP: begin
          res_value  = '0;
          res_status = cls_pkg::STAT_EMPTY;
        end
        default: begin
          if ((op == cls_pkg::OP_REPLACE) && pos_zero) begin
            res_status = cls_pkg::STAT_NOPOS;
          end else if (do_replace) begin
            res_index = position_i;
          end else if (list_full) begin
            res_status = cls_pkg::STAT_FULL;
          end else begin
            res_index = cls_pkg::PosW'(count_q + CW'(1));
          end
        end
      endcase
    end
  end

  // Count and dump pointer
  always_comb begin
    count_d = count_q;
    if (wr_append) begin
      count_d = count_q + CW'(1);
    end else if (wr_remove) begin
      count_d = count_q - CW'(1);
    end
    ptr_d = ptr_q;
    if (cmd_i.dump_start) begin
      ptr_d = '0;
    end else if (cmd_i.dump_step) begin
      ptr_d = ptr_q + AW'(1);
    end
  end

  // Output register: load a result, drop it once transferred
  assign load = cmd_i.exec || cmd_i.dump_step;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_value_q  <= res_value;
      out_index_q  <= res_index;
      out_status_q <= res_status;
      out_last_q   <= res_last;
    end
  end

  assign stat_o.out_free   = !out_valid_q || out_ready_i;
  assign stat_o.list_empty = (count_q == '0);
  assign stat_o.dump_last  = dump_last;

  assign out_valid_o = out_valid_q;
  assign value_out_o = out_value_q;
  assign index_out_o = out_index_q;
  assign status_o    = out_status_q;
  assign last_o      = out_last_q;

  // Count stays within the list depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(Depth))
    else $error("entry count exceeds depth");

  // A successful append grows the list by one
  a_append_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_append |=> count_q == $past(count_q) + CW'(1))
    else $error("append did not grow the list");

  // Results are loaded only into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || out_ready_i))
    else $error("result overwrote a pending result");

endmodule

### sv/cls_controller.sv
module cls_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  cls_pkg::dp_stat_t  stat_i,
  output cls_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_DUMP = 2'b10
  } fsm_e;

  fsm_e state_q, state_d;
  logic accept;

  // Take an item only when idle and the output register is free
  assign in_ready_o = (state_q == FSM_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d          = state_q;
    cmd_o.exec       = 1'b0;
    cmd_o.dump_start = 1'b0;
    cmd_o.dump_step  = 1'b0;
    case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if ((cls_pkg::op_e'(operation_i) == cls_pkg::OP_DUMP) && !stat_i.list_empty) begin
            cmd_o.dump_start = 1'b1;
            state_d          = FSM_DUMP;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      FSM_DUMP: begin
        // Emit one entry per free output slot
        if (stat_i.out_free) begin
          cmd_o.dump_step = 1'b1;
          if (stat_i.dump_last) begin
            state_d = FSM_IDLE;
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // No item is taken while a dump runs
  a_dump_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FSM_DUMP) |-> !in_ready_o)
    else $error("input ready during dump");

  // Final dump step returns to idle
  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.dump_step && stat_i.dump_last) |=> (state_q == FSM_IDLE))
    else $error("dump did not end on last entry");

  // Starting a dump never also emits a result
  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.dump_start |-> !cmd_o.exec && !cmd_o.dump_step)
    else $error("dump start collided with a result");

endmodule

### bench/compacting_list_store_tb.sv
module compacting_list_store_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = cls_pkg::DefDepth;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned PhaseItems = 37;
  localparam int unsigned NumPhases  = 7;

  typedef struct packed {
    logic [cls_pkg::ValW-1:0] value;
    logic [cls_pkg::PosW-1:0] index;
    cls_pkg::status_e         status;
    logic                     last;
  } list_result_t;

  typedef struct packed {
    cls_pkg::op_e             op;
    logic [cls_pkg::ValW-1:0] value;
    logic [cls_pkg::PosW-1:0] pos;
    logic                     typed;
    list_result_t             res;
  } stim_row_t;

  typedef enum {MIX_GROW, MIX_BALANCED, MIX_SHRINK} mix_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            in_valid = 1'b0;
  logic                            in_ready_o;
  cls_pkg::op_e                    operation = cls_pkg::OP_APPEND;
  logic signed [cls_pkg::ValW-1:0] value = '0;
  logic [cls_pkg::PosW-1:0]        position = '0;
  logic                            out_valid_o;
  logic                            out_ready = 1'b0;
  logic signed [cls_pkg::ValW-1:0] value_out_o;
  logic [cls_pkg::PosW-1:0]        index_out_o;
  logic [cls_pkg::StatW-1:0]       status_o;
  logic                            last_o;

  // Shadow copy of the list and the results it predicts
  logic [cls_pkg::ValW-1:0] shadow_cells [Depth];
  int unsigned              shadow_count = 0;
  list_result_t             pending_results [$];

  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned ready_hold = 0;
  bit          no_idle = 1'b0;

  compacting_list_store u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (operation),
    .value_i     (value),
    .position_i  (position),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .value_out_o (value_out_o),
    .index_out_o (index_out_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic list_result_t mk_result(logic [cls_pkg::ValW-1:0] v,
                                             logic [cls_pkg::PosW-1:0] idx,
                                             cls_pkg::status_e st, logic lst);
    list_result_t r;
    r.value  = v;
    r.index  = idx;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  function automatic void append_cell(logic [cls_pkg::ValW-1:0] v);
    if (shadow_count >= Depth) begin
      pending_results.push_back(mk_result(v, '0, cls_pkg::STAT_FULL, 1'b1));
    end else begin
      shadow_cells[shadow_count] = v;
      shadow_count++;
      pending_results.push_back(mk_result(v, cls_pkg::PosW'(shadow_count),
                                          cls_pkg::STAT_OK, 1'b1));
    end
  endfunction

  // Apply one list operation to the shadow list and queue its results
  function automatic void apply_list_op(cls_pkg::op_e op, logic [cls_pkg::ValW-1:0] v,
                                        logic [cls_pkg::PosW-1:0] pos);
    int unsigned n;
    logic [cls_pkg::ValW-1:0] removed;
    case (op)
      cls_pkg::OP_APPEND: begin
        append_cell(v);
      end
      cls_pkg::OP_REMOVE: begin
        if (pos == 0 || pos > shadow_count) begin
          pending_results.push_back(mk_result('0, pos, cls_pkg::STAT_NOPOS, 1'b1));
        end else begin
          removed = shadow_cells[pos-1];
          for (int unsigned k = pos - 1; k + 1 < shadow_count; k++) begin
            shadow_cells[k] = shadow_cells[k+1];
          end
          shadow_count--;
          pending_results.push_back(mk_result(removed, pos, cls_pkg::STAT_OK, 1'b1));
        end
      end
      cls_pkg::OP_DUMP: begin
        n = (shadow_count > cls_pkg::MaxResults) ? cls_pkg::MaxResults : shadow_count;
        if (n == 0) begin
          pending_results.push_back(mk_result('0, '0, cls_pkg::STAT_EMPTY, 1'b1));
        end else begin
          for (int unsigned k = 0; k < n; k++) begin
            pending_results.push_back(mk_result(shadow_cells[k], cls_pkg::PosW'(k + 1),
                                                cls_pkg::STAT_OK, (k + 1 == n)));
          end
        end
      end
      default: begin
        if (pos == 0) begin
          pending_results.push_back(mk_result(v, '0, cls_pkg::STAT_NOPOS, 1'b1));
        end else if (pos > shadow_count) begin
          append_cell(v);
        end else begin
          shadow_cells[pos-1] = v;
          pending_results.push_back(mk_result(v, pos, cls_pkg::STAT_OK, 1'b1));
        end
      end
    endcase
  endfunction

  function automatic stim_row_t mk_row(cls_pkg::op_e op, logic [cls_pkg::ValW-1:0] v,
                                       logic [cls_pkg::PosW-1:0] pos, logic typed,
                                       logic [cls_pkg::ValW-1:0] rv,
                                       logic [cls_pkg::PosW-1:0] ri,
                                       cls_pkg::status_e rs);
    stim_row_t row;
    row.op    = op;
    row.value = v;
    row.pos   = pos;
    row.typed = typed;
    row.res   = mk_result(rv, ri, rs, 1'b1);
    return row;
  endfunction

  // Position: mostly in use, sometimes one past the end, zero or anything
  function automatic logic [cls_pkg::PosW-1:0] pick_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75 && shadow_count > 0) return cls_pkg::PosW'($urandom_range(1, shadow_count));
    if (r < 85) return cls_pkg::PosW'(shadow_count + 1);
    if (r < 92) return '0;
    return cls_pkg::PosW'($urandom_range(0, 63));
  endfunction

  function automatic logic [cls_pkg::ValW-1:0] pick_value();
    case ($urandom_range(0, 39))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  function automatic cls_pkg::op_e pick_op(mix_e mix);
    int unsigned r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 85) return cls_pkg::OP_APPEND;
        if (r < 91) return cls_pkg::OP_REPLACE;
        if (r < 97) return cls_pkg::OP_DUMP;
        return cls_pkg::OP_REMOVE;
      end
      MIX_SHRINK: begin
        if (r < 70) return cls_pkg::OP_REMOVE;
        if (r < 80) return cls_pkg::OP_DUMP;
        if (r < 90) return cls_pkg::OP_APPEND;
        return cls_pkg::OP_REPLACE;
      end
      default: begin
        if (r < 30) return cls_pkg::OP_APPEND;
        if (r < 60) return cls_pkg::OP_REMOVE;
        if (r < 75) return cls_pkg::OP_DUMP;
        return cls_pkg::OP_REPLACE;
      end
    endcase
  endfunction

  // Present one item after a random idle and hold it until the transfer
  task automatic send_item(cls_pkg::op_e op, logic [cls_pkg::ValW-1:0] v,
                           logic [cls_pkg::PosW-1:0] pos);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    operation <= op;
    value     <= v;
    position  <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold off the sender until every queued result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Receiver stalls in stretches of random length
  always @(posedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= ($urandom_range(0, 99) < 65);
      ready_hold <= pick_gap();
    end
  end

  function automatic void check_field(string name, logic [cls_pkg::ValW-1:0] exp_v,
                                      logic [cls_pkg::ValW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // Compare each output transfer with the oldest queued result
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing pending, expected none actual value %h index %0d",
                 $time, value_out_o, index_out_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        check_field("value_out", want.value, value_out_o);
        check_field("index_out", cls_pkg::ValW'(want.index), cls_pkg::ValW'(index_out_o));
        check_field("status", cls_pkg::ValW'(want.status), cls_pkg::ValW'(status_o));
        check_field("last", cls_pkg::ValW'(want.last), cls_pkg::ValW'(last_o));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    stim_row_t                rows [$];
    stim_row_t                row;
    mix_e                     plan [NumPhases];
    cls_pkg::op_e             op;
    logic [cls_pkg::ValW-1:0] v;
    logic [cls_pkg::PosW-1:0] pos;

    plan = '{MIX_GROW, MIX_BALANCED, MIX_SHRINK, MIX_GROW, MIX_BALANCED, MIX_GROW,
             MIX_SHRINK};

    // Empty list, zero and out-of-range positions, value extremes
    rows.push_back(mk_row(cls_pkg::OP_DUMP, 32'h0, 6'd0, 1'b1,
                          32'h0, 6'd0, cls_pkg::STAT_EMPTY));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd1, 1'b1,
                          32'h0, 6'd1, cls_pkg::STAT_NOPOS));
    rows.push_back(mk_row(cls_pkg::OP_REPLACE, 32'h7FFF_FFFF, 6'd0, 1'b1,
                          32'h7FFF_FFFF, 6'd0, cls_pkg::STAT_NOPOS));
    rows.push_back(mk_row(cls_pkg::OP_APPEND, 32'h7FFF_FFFF, 6'd0, 1'b1,
                          32'h7FFF_FFFF, 6'd1, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_APPEND, 32'h8000_0000, 6'd63, 1'b1,
                          32'h8000_0000, 6'd2, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_APPEND, 32'h0, 6'd0, 1'b1,
                          32'h0, 6'd3, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_APPEND, 32'hFFFF_FFFF, 6'd0, 1'b1,
                          32'hFFFF_FFFF, 6'd4, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_DUMP, 32'h0, 6'd0, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h5555_5555, 6'd0, 1'b1,
                          32'h0, 6'd0, cls_pkg::STAT_NOPOS));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd63, 1'b1,
                          32'h0, 6'd63, cls_pkg::STAT_NOPOS));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd5, 1'b1,
                          32'h0, 6'd5, cls_pkg::STAT_NOPOS));
    rows.push_back(mk_row(cls_pkg::OP_REPLACE, 32'h1234_5678, 6'd2, 1'b1,
                          32'h1234_5678, 6'd2, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REPLACE, 32'hDEAD_BEEF, 6'd63, 1'b1,
                          32'hDEAD_BEEF, 6'd5, cls_pkg::STAT_OK));
    // Head and tail removes, rewrites at the boundary
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd1, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd4, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_DUMP, 32'h0, 6'd0, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REPLACE, 32'hAAAA_AAAA, 6'd3, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REPLACE, 32'h0F0F_0F0F, 6'd4, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd2, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_DUMP, 32'h0, 6'd0, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd1, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd1, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_REMOVE, 32'h0, 6'd1, 1'b0,
                          32'h0, 6'd0, cls_pkg::STAT_OK));
    rows.push_back(mk_row(cls_pkg::OP_DUMP, 32'h0, 6'd0, 1'b1,
                          32'h0, 6'd0, cls_pkg::STAT_EMPTY));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; typed rows replace the predicted result with their own
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.op, row.value, row.pos);
      apply_list_op(row.op, row.value, row.pos);
      if (row.typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(row.res);
      end
    end
    drain_results();

    // Random phases, each drained before the next
    for (int ph = 0; ph < NumPhases; ph++) begin
      no_idle = (ph == 3);
      for (int i = 0; i < PhaseItems; i++) begin
        op  = pick_op(plan[ph]);
        v   = pick_value();
        pos = pick_pos();
        send_item(op, v, pos);
        apply_list_op(op, v, pos);
      end
      drain_results();
    end
    no_idle = 1'b0;

    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
